// ===== src/fdep_pkg.sv =====
`default_nettype none

package fdep_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int OFF_W        = $clog2(SECTOR_BYTES);
   localparam int DOT_BYTES    = 64;
   localparam int ENTRY_BYTES  = 32;
   localparam int POS_W        = $clog2(ENTRY_BYTES);

   localparam logic [7:0] BYTE_DELETED = 8'hE5;
   localparam logic [7:0] BYTE_END     = 8'h00;
   localparam logic [7:0] BYTE_PAD     = 8'hFF;
   localparam logic [7:0] BYTE_SPACE   = 8'h20;
   localparam logic [7:0] ATTR_LFN     = 8'h0F;
   localparam logic [7:0] ATTR_DIR     = 8'h10;
   localparam logic [11:0] YEAR_BASE   = 12'd1980;

   localparam logic [POS_W-1:0] POS_ATTR   = POS_W'(11);
   localparam logic [POS_W-1:0] POS_EXT_LO = POS_W'(8);
   localparam logic [POS_W-1:0] POS_EXT_HI = POS_W'(10);
   localparam logic [POS_W-1:0] POS_REC_LO = POS_W'(20);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(ENTRY_BYTES - 1);

   // long-name character offsets 1-10, 14-25, 28-31
   localparam logic [ENTRY_BYTES-1:0] LFN_CHAR_MASK = 32'hF3FF_C7FE;

   typedef enum logic [2:0] {
      KIND_LONG  = 3'd0,
      KIND_SHORT = 3'd1,
      KIND_EXT   = 3'd2,
      KIND_REC   = 3'd3,
      KIND_EOT   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REC,
      ST_EOT
   } seq_state_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      logic [7:0]       data;
   } wr_type;

   typedef struct packed {
      logic                   go;
      logic                   eot;
      logic                   is_long;
      logic                   name_en;
      logic                   ext_en;
      logic [3:0]             name_end;
      logic [ENTRY_BYTES-1:0] lmask;
      logic [7:0]             attr;
   } job_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  name_char;
      logic        last;
      logic [3:0]  attribute;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [31:0] first_cluster;
      logic [31:0] file_size;
   } res_type;

   function automatic logic [3:0] attr_code(input logic [7:0] a);
      logic [3:0] code;
      unique case (a)
         8'h01:   code = 4'd1;
         8'h02:   code = 4'd2;
         8'h04:   code = 4'd3;
         8'h08:   code = 4'd4;
         8'h10:   code = 4'd5;
         8'h20:   code = 4'd6;
         8'h40:   code = 4'd7;
         8'h80:   code = 4'd8;
         default: code = 4'd0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== src/fdep_ifs.sv =====
`default_nettype none

interface fdep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface fdep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  name_char;
   logic        last;
   logic [3:0]  attribute;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [4:0]  day;
   logic [3:0]  month;
   logic [11:0] year;
   logic [31:0] first_cluster;
   logic [31:0] file_size;

   modport source (output valid, output kind, output name_char, output last,
                   output attribute, output hour, output minute, output second,
                   output day, output month, output year, output first_cluster,
                   output file_size, input ready);
   modport sink   (input valid, input kind, input name_char, input last,
                   input attribute, input hour, input minute, input second,
                   input day, input month, input year, input first_cluster,
                   input file_size, output ready);
endinterface

interface fdep_csr_if;
   logic valid;
   logic ready;
   logic skip_dot_entries;

   modport source (output valid, output skip_dot_entries, input ready);
   modport sink   (input valid, input skip_dot_entries, output ready);
endinterface

`default_nettype wire

// ===== src/fdep_buf.sv =====
`default_nettype none

module fdep_buf (
   input  logic                      clock,
   input  fdep_pkg::wr_type          wr,
   input  logic [fdep_pkg::POS_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);
   import fdep_pkg::*;

   logic [7:0] entry_ff [ENTRY_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/fdep_front.sv =====
`default_nettype none

module fdep_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              start_req,
   input  logic              skip_dot,
   output fdep_pkg::wr_type  wr,
   output fdep_pkg::job_type job
);
   import fdep_pkg::*;

   logic [OFF_W-1:0]       off_ff, off_in;
   logic                   first_ff, first_in;
   logic                   ended_ff, ended_in;
   logic                   lpend_ff, lpend_in;
   logic [7:0]             byte0_ff, byte0_in;
   logic [7:0]             attr_ff, attr_in;
   logic [7:0]             spc_ff, spc_in;
   logic [ENTRY_BYTES-1:0] chr_ff, chr_in;

   function automatic logic [3:0] trim_end(input logic [7:0] spc);
      logic [3:0] e;
      e = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (!spc[i]) begin
            e = 4'(i + 1);
         end
      end
      return e;
   endfunction

   always_comb begin
      logic [OFF_W-1:0]       off;
      logic                   first;
      logic                   ended;
      logic                   lp;
      logic                   skip;
      logic [POS_W-1:0]       pos;
      logic                   is_long;
      logic [ENTRY_BYTES-1:0] lmask;

      off      = start_req ? '0 : off_ff;
      first    = start_req | first_ff;
      ended    = !start_req & ended_ff;
      lp       = !start_req & lpend_ff;
      skip     = 1'b0;
      pos      = off[POS_W-1:0];
      is_long  = (attr_ff == ATTR_LFN);
      lmask    = '0;
      off_in   = off_ff;
      first_in = first_ff;
      ended_in = ended_ff;
      lpend_in = lpend_ff;
      byte0_in = byte0_ff;
      attr_in  = attr_ff;
      spc_in   = spc_ff;
      chr_in   = chr_ff;
      wr       = '0;
      job      = '0;

      if (accept) begin
         off_in   = off;
         first_in = first;
         ended_in = ended;
         lpend_in = lp;
         if (!ended) begin
            skip = skip_dot && first &&
                   ((OFF_W + 1)'(off) < (OFF_W + 1)'(DOT_BYTES));
            if (off == OFF_W'(SECTOR_BYTES - 1)) begin
               off_in   = '0;
               first_in = 1'b0;
            end else begin
               off_in = off + 1'b1;
            end
            if (!skip) begin
               wr.en   = 1'b1;
               wr.addr = pos;
               wr.data = data_byte;
               chr_in[pos] = (data_byte != BYTE_END) && (data_byte != BYTE_PAD);
               if (pos < POS_W'(8)) begin
                  spc_in[pos[2:0]] = (data_byte == BYTE_SPACE);
               end
               if (pos == '0) begin
                  byte0_in = data_byte;
               end
               if (pos == POS_ATTR) begin
                  attr_in = data_byte;
               end
               lmask = chr_in & LFN_CHAR_MASK;
               if (pos == '0 && data_byte == BYTE_END) begin
                  ended_in = 1'b1;
                  job.go   = 1'b1;
                  job.eot  = 1'b1;
               end else if (pos == POS_LAST && byte0_ff != BYTE_DELETED) begin
                  lpend_in     = is_long;
                  job.go       = !is_long || (lmask != '0);
                  job.is_long  = is_long;
                  job.name_en  = !is_long && !lp;
                  job.ext_en   = (attr_ff != ATTR_DIR);
                  job.name_end = trim_end(spc_ff);
                  job.lmask    = lmask;
                  job.attr     = attr_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         first_ff <= 1'b1;
         ended_ff <= 1'b0;
         lpend_ff <= 1'b0;
      end else begin
         off_ff   <= off_in;
         first_ff <= first_in;
         ended_ff <= ended_in;
         lpend_ff <= lpend_in;
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      attr_ff  <= attr_in;
      spc_ff   <= spc_in;
      chr_ff   <= chr_in;
   end

endmodule

`default_nettype wire

// ===== src/fdep_seq.sv =====
`default_nettype none

module fdep_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  fdep_pkg::job_type          job,
   output logic                       idle,
   output logic [fdep_pkg::POS_W-1:0] rd_addr,
   input  logic [7:0]                 rd_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output fdep_pkg::res_type          out
);
   import fdep_pkg::*;

   seq_state_type          state_ff, state_in;
   logic [POS_W-1:0]       idx_ff, idx_in;
   logic                   long_ff, long_in;
   logic                   name_en_ff, name_en_in;
   logic                   ext_en_ff, ext_en_in;
   logic [3:0]             end_ff, end_in;
   logic [ENTRY_BYTES-1:0] lmask_ff, lmask_in;
   logic [7:0]             attr_ff, attr_in;
   logic [95:0]            rec_ff, rec_in;
   logic                   out_valid_ff, out_valid_in;
   res_type                out_ff, out_in;
   logic                   out_free;
   logic                   load;

   assign out_free = !out_valid_ff || out_ready;
   assign idle     = (state_ff == ST_IDLE);

   always_comb begin
      logic                   emit;
      logic                   last_chr;
      logic [ENTRY_BYTES-1:0] rem;
      res_type                res;

      state_in   = state_ff;
      idx_in     = idx_ff;
      long_in    = long_ff;
      name_en_in = name_en_ff;
      ext_en_in  = ext_en_ff;
      end_in     = end_ff;
      lmask_in   = lmask_ff;
      attr_in    = attr_ff;
      rec_in     = rec_ff;
      rd_addr    = idx_ff;
      load       = 1'b0;
      emit       = 1'b0;
      rem        = lmask_ff >> idx_ff;
      last_chr   = (rem[ENTRY_BYTES-1:1] == '0);
      res        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job.go) begin
               if (job.eot) begin
                  state_in = ST_EOT;
               end else begin
                  state_in   = ST_SCAN;
                  idx_in     = job.is_long ? POS_W'(1) : '0;
                  long_in    = job.is_long;
                  name_en_in = job.name_en;
                  ext_en_in  = job.ext_en;
                  end_in     = job.name_end;
                  lmask_in   = job.lmask;
                  attr_in    = job.attr;
                  rd_addr    = idx_in;
               end
            end
         end
         ST_SCAN: begin
            res.name_char = rd_data;
            if (long_ff) begin
               emit     = lmask_ff[idx_ff];
               res.kind = KIND_LONG;
               res.last = last_chr;
            end else if (name_en_ff && (idx_ff < POS_W'(end_ff))) begin
               emit     = 1'b1;
               res.kind = KIND_SHORT;
            end else if (ext_en_ff && idx_ff >= POS_EXT_LO && idx_ff <= POS_EXT_HI) begin
               emit     = 1'b1;
               res.kind = KIND_EXT;
            end
            load = emit && out_free;
            if (!emit || out_free) begin
               if (idx_ff >= POS_REC_LO) begin
                  rec_in = {rd_data, rec_ff[95:8]};
               end
               if (long_ff && emit && last_chr) begin
                  state_in = ST_IDLE;
               end else if (idx_ff == POS_LAST) begin
                  state_in = long_ff ? ST_IDLE : ST_REC;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
               rd_addr = idx_in;
            end
         end
         ST_REC: begin
            res.kind          = KIND_REC;
            res.last          = 1'b1;
            res.attribute     = attr_code(attr_ff);
            res.hour          = rec_ff[31:27];
            res.minute        = {rec_ff[26:24], rec_ff[23:21]};
            res.second        = {rec_ff[20:16], 1'b0};
            res.day           = rec_ff[36:32];
            res.month         = {rec_ff[40], rec_ff[39:37]};
            res.year          = 12'(rec_ff[47:41]) + YEAR_BASE;
            res.first_cluster = {rec_ff[15:0], rec_ff[63:48]};
            res.file_size     = rec_ff[95:64];
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EOT: begin
            res.kind = KIND_EOT;
            res.last = 1'b1;
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_in = load ? res : out_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      long_ff    <= long_in;
      name_en_ff <= name_en_in;
      ext_en_ff  <= ext_en_in;
      end_ff     <= end_in;
      lmask_ff   <= lmask_in;
      attr_ff    <= attr_in;
      rec_ff     <= rec_in;
      out_ff     <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out       = out_ff;

   a_job_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      job.go |-> state_ff == ST_IDLE)
      else $error("job issued while sequencer busy");

   a_long_scan_has_chars: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && long_ff) |-> lmask_ff != '0)
      else $error("long-name scan with no characters");

   a_rec_after_full_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REC |-> idx_ff == POS_LAST)
      else $error("record stage entered before scan finished");

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |-> !load)
      else $error("output register overwritten while stalled");

   a_main_chars_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !long_ff && load) |=> !out_ff.last)
      else $error("name character of main entry flagged last");

endmodule

`default_nettype wire

// ===== src/fat_directory_entry_parser.sv =====
// FAT directory entry parser.
// req_port carries the directory region one byte per request; start_req marks
// the first byte of a new directory read. csr_port writes skip_dot_entries
// and is always ready; write it only while the block is idle.
// rsp_port returns name characters, entry records and the end-of-table mark,
// with last set on the final response that a request caused.
// A byte that causes no response leaves the sequencer idle. The last byte of
// an entry that is not deleted (a long-name entry also needs characters)
// starts a scan of the 32-byte entry buffer through its registered read port,
// one buffer byte per cycle unless a character waits for a stalled output
// register; characters leave as the scan reaches them, the record passes the
// record state after the scan ends, and the end-of-table mark passes the
// end-of-table state. req_port.ready is low while the sequencer is busy.
// A stalled receiver holds the output register and stops the scan; the next
// request is still taken once the final response sits in the output register.
// Reset (synchronous) resets the offset, flags, skip register, sequencer state and response valid.
`default_nettype none

module fat_directory_entry_parser (
   input  logic              clock,
   input  logic              reset,
   fdep_req_if.sink          req_port,
   fdep_rsp_if.source        rsp_port,
   fdep_csr_if.sink          csr_port
);
   import fdep_pkg::*;

   logic             skip_ff, skip_in;
   logic             accept;
   logic             idle;
   wr_type           wr;
   job_type          job;
   logic [POS_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   res_type          out;

   assign csr_port.ready = 1'b1;
   assign skip_in = csr_port.valid ? csr_port.skip_dot_entries : skip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
      end else begin
         skip_ff <= skip_in;
      end
   end

   assign req_port.ready = idle;
   assign accept = req_port.valid && idle;

   fdep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_port.data_byte),
      .start_req (req_port.start_req),
      .skip_dot  (skip_ff),
      .wr        (wr),
      .job       (job)
   );

   fdep_buf u_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fdep_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .idle      (idle),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out       (out)
   );

   assign rsp_port.kind          = out.kind;
   assign rsp_port.name_char     = out.name_char;
   assign rsp_port.last          = out.last;
   assign rsp_port.attribute     = out.attribute;
   assign rsp_port.hour          = out.hour;
   assign rsp_port.minute        = out.minute;
   assign rsp_port.second        = out.second;
   assign rsp_port.day           = out.day;
   assign rsp_port.month         = out.month;
   assign rsp_port.year          = out.year;
   assign rsp_port.first_cluster = out.first_cluster;
   assign rsp_port.file_size     = out.file_size;

endmodule

`default_nettype wire
